// File: hdl/a2d_pkg.sv
// ----------------------------------------------------------------------------
// a2d_pkg
// Shared types and constants for the angle to degrees/minutes/seconds block:
// format codes, field record and the grid spacing format decode.
// ----------------------------------------------------------------------------
package a2d_pkg;

    localparam int ANGLE_W = 33;
    localparam int GRID_W  = 31;

    localparam logic [GRID_W-1:0] GRID_RESET = 31'd16777216;

    localparam logic [1:0] FMT_DEG = 2'd0;
    localparam logic [1:0] FMT_MIN = 2'd1;
    localparam logic [1:0] FMT_SEC = 2'd2;
    localparam logic [1:0] FMT_TEN = 2'd3;

    typedef struct packed {
        logic [7:0] deg;
        logic [5:0] mins;
        logic [5:0] secs;
        logic [3:0] tenths;
    } dms_t;

    function automatic logic [1:0] pick_format(input logic [GRID_W-1:0] g,
                                               input int unsigned fb);
        logic [63:0] one;
        logic [63:0] g64;
        logic [63:0] g60;
        logic [63:0] g3600;
        logic [63:0] top;
        one   = 64'd1 << fb;
        g64   = 64'(g);
        g60   = g64 * 64'd60;
        g3600 = g64 * 64'd3600;
        top   = one * 64'd59;
        if (g64 >= one)
            return FMT_DEG;
        else if (g60 >= one && g60 <= top)
            return FMT_MIN;
        else if (g3600 >= one && g3600 <= top)
            return FMT_SEC;
        else
            return FMT_TEN;
    endfunction

endpackage

// File: hdl/angle_to_dms_fields.sv
// Throughput: one beat per cycle unless out_stall holds the output; five
//   register stages advance together wherever the next stage is empty or
//   moving.
// Reset: rst_n clears all stage valid bits and sets the format to whole
//   degrees (grid spacing of 1 degree).
// ----------------------------------------------------------------------------
// angle_to_dms_fields
// Converts a signed fixed-point angle into hemisphere, degree, minute, second
// and tenth fields at a precision picked from the configured grid spacing.
// ----------------------------------------------------------------------------
module angle_to_dms_fields #(
    parameter int FRACTION_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [a2d_pkg::GRID_W-1:0]          cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [a2d_pkg::ANGLE_W-1:0]  angle,
    input  logic [1:0]                          axis_kind,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          hemisphere,
    output logic [7:0]                          whole_degrees,
    output logic [5:0]                          arc_minutes,
    output logic [5:0]                          arc_seconds,
    output logic [3:0]                          second_tenths,
    output logic [1:0]                          format_used,
    output logic                                bad_axis
);

    localparam int F     = FRACTION_BITS;
    localparam int AW    = a2d_pkg::ANGLE_W;
    localparam int MAG_W = (F + 8 > AW) ? F + 8 : AW;
    localparam int T60_W = F + 6;
    localparam int T10_W = F + 4;
    localparam logic [MAG_W-1:0] SAT_MAG = MAG_W'(180) << F;

    logic [1:0] cfg_fmt;

    a2d_cfg #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fmt         (cfg_fmt)
    );

    // stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (out_ready)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // stage 1: magnitude, saturate, split
    logic [AW-1:0]    angle_u;
    logic             neg;
    logic [AW-1:0]    mag_raw;
    logic [MAG_W-1:0] mag_ext;
    logic [MAG_W-1:0] mag_sat;

    assign angle_u = angle;
    assign neg     = angle_u[AW-1];
    assign mag_raw = neg ? (AW'(0) - angle_u) : angle_u;
    assign mag_ext = MAG_W'(mag_raw);
    assign mag_sat = (mag_ext > SAT_MAG) ? SAT_MAG : mag_ext;

    logic         s1_bad_reg;
    logic [1:0]   s1_hemi_reg;
    logic [1:0]   s1_fmt_reg;
    logic [7:0]   s1_deg_reg;
    logic [F-1:0] s1_frac_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_bad_reg  <= axis_kind[1];
            s1_hemi_reg <= {axis_kind[0], neg};
            s1_fmt_reg  <= cfg_fmt;
            s1_deg_reg  <= mag_sat[F+7:F];
            s1_frac_reg <= mag_sat[F-1:0];
        end
    end

    // stage 2: minutes
    logic [T60_W-1:0] t1;
    assign t1 = T60_W'(s1_frac_reg) * T60_W'(60);

    logic         s2_bad_reg;
    logic [1:0]   s2_hemi_reg;
    logic [1:0]   s2_fmt_reg;
    logic [7:0]   s2_deg_reg;
    logic [5:0]   s2_mins_reg;
    logic [F-1:0] s2_rem_reg;
    logic [1:0]   s2_rbits_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_bad_reg   <= s1_bad_reg;
            s2_hemi_reg  <= s1_hemi_reg;
            s2_fmt_reg   <= s1_fmt_reg;
            s2_deg_reg   <= s1_deg_reg;
            s2_mins_reg  <= t1[F+5:F];
            s2_rem_reg   <= t1[F-1:0];
            s2_rbits_reg <= {t1[F-1], s1_frac_reg[F-1]};
        end
    end

    // stage 3: seconds
    logic [T60_W-1:0] t2;
    assign t2 = T60_W'(s2_rem_reg) * T60_W'(60);

    logic         s3_bad_reg;
    logic [1:0]   s3_hemi_reg;
    logic [1:0]   s3_fmt_reg;
    logic [7:0]   s3_deg_reg;
    logic [5:0]   s3_mins_reg;
    logic [5:0]   s3_secs_reg;
    logic [F-1:0] s3_rem_reg;
    logic [2:0]   s3_rbits_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_bad_reg   <= s2_bad_reg;
            s3_hemi_reg  <= s2_hemi_reg;
            s3_fmt_reg   <= s2_fmt_reg;
            s3_deg_reg   <= s2_deg_reg;
            s3_mins_reg  <= s2_mins_reg;
            s3_secs_reg  <= t2[F+5:F];
            s3_rem_reg   <= t2[F-1:0];
            s3_rbits_reg <= {t2[F-1], s2_rbits_reg};
        end
    end

    // stage 4: tenths
    logic [T10_W-1:0] t3;
    assign t3 = T10_W'(s3_rem_reg) * T10_W'(10);

    logic          s4_bad_reg;
    logic [1:0]    s4_hemi_reg;
    logic [1:0]    s4_fmt_reg;
    a2d_pkg::dms_t s4_dms_reg;
    logic [3:0]    s4_rbits_reg;

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
        begin
            s4_bad_reg          <= s3_bad_reg;
            s4_hemi_reg         <= s3_hemi_reg;
            s4_fmt_reg          <= s3_fmt_reg;
            s4_dms_reg.deg      <= s3_deg_reg;
            s4_dms_reg.mins     <= s3_mins_reg;
            s4_dms_reg.secs     <= s3_secs_reg;
            s4_dms_reg.tenths   <= t3[F+3:F];
            s4_rbits_reg        <= {t3[F-1], s3_rbits_reg};
        end
    end

    // stage 5: round, carry, output
    a2d_pkg::dms_t dms_next;

    a2d_round u_round (
        .trunc   (s4_dms_reg),
        .rbits   (s4_rbits_reg),
        .fmt     (s4_fmt_reg),
        .rounded (dms_next)
    );

    logic          out_bad_reg;
    logic [1:0]    out_hemi_reg;
    logic [1:0]    out_fmt_reg;
    a2d_pkg::dms_t out_dms_reg;

    always_ff @(posedge clk)
    begin
        if (out_ready && s4_valid_reg)
        begin
            out_bad_reg  <= s4_bad_reg;
            out_hemi_reg <= s4_bad_reg ? 2'd0 : s4_hemi_reg;
            out_fmt_reg  <= s4_bad_reg ? a2d_pkg::FMT_DEG : s4_fmt_reg;
            out_dms_reg  <= s4_bad_reg ? '0 : dms_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bad_axis      = out_bad_reg;
    assign hemisphere    = out_hemi_reg;
    assign format_used   = out_fmt_reg;
    assign whole_degrees = out_dms_reg.deg;
    assign arc_minutes   = out_dms_reg.mins;
    assign arc_seconds   = out_dms_reg.secs;
    assign second_tenths = out_dms_reg.tenths;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_axis) |-> (hemisphere == 2'd0 && whole_degrees == 8'd0 &&
            arc_minutes == 6'd0 && arc_seconds == 6'd0 && second_tenths == 4'd0 &&
            format_used == a2d_pkg::FMT_DEG))
        else $error("bad axis beat carries nonzero fields");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (whole_degrees <= 8'd180 && arc_minutes <= 6'd59 &&
            arc_seconds <= 6'd59 && second_tenths <= 4'd9))
        else $error("output field out of range");

    a_deg_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && format_used == a2d_pkg::FMT_DEG) |->
            (arc_minutes == 6'd0 && arc_seconds == 6'd0 && second_tenths == 4'd0))
        else $error("degree format shows finer fields");

    a_min_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && format_used == a2d_pkg::FMT_MIN) |->
            (arc_seconds == 6'd0 && second_tenths == 4'd0))
        else $error("minute format shows finer fields");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat did not enter the first stage");
`endif

endmodule

// File: hdl/a2d_cfg.sv
// ----------------------------------------------------------------------------
// a2d_cfg
// Grid spacing register port. Decodes the written spacing into the display
// format and holds the format code.
// ----------------------------------------------------------------------------
module a2d_cfg #(
    parameter int FRACTION_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [a2d_pkg::GRID_W-1:0]   cfg_wr_data,
    output logic [1:0]                   fmt
);

    localparam logic [1:0] FMT_RESET =
        a2d_pkg::pick_format(a2d_pkg::GRID_RESET, FRACTION_BITS);

    logic [1:0] fmt_reg;
    logic [1:0] fmt_next;

    assign fmt_next = a2d_pkg::pick_format(cfg_wr_data, FRACTION_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RESET;
        end
        else if (cfg_wr_en)
        begin
            fmt_reg <= fmt_next;
        end
    end

    assign fmt = fmt_reg;

endmodule

// File: hdl/a2d_round.sv
// ----------------------------------------------------------------------------
// a2d_round
// Rounds the last shown field half up and ripples the carry into the coarser
// fields; zeroes the fields that the format does not show.
// ----------------------------------------------------------------------------
module a2d_round (
    input  a2d_pkg::dms_t trunc,
    input  logic [3:0]    rbits,
    input  logic [1:0]    fmt,
    output a2d_pkg::dms_t rounded
);

    logic [3:0] t_in;
    logic [5:0] s_in;
    logic [5:0] m_in;
    logic       t_inc;
    logic       s_inc;
    logic       m_inc;
    logic       d_inc;
    logic [3:0] t_sum;
    logic [5:0] s_sum;
    logic [5:0] m_sum;
    logic       ct;
    logic       cs;
    logic       cm;

    always_comb
    begin
        t_in  = '0;
        s_in  = '0;
        m_in  = '0;
        t_inc = 1'b0;
        s_inc = 1'b0;
        m_inc = 1'b0;
        d_inc = 1'b0;
        unique case (fmt)
            a2d_pkg::FMT_DEG:
            begin
                d_inc = rbits[0];
            end
            a2d_pkg::FMT_MIN:
            begin
                m_in  = trunc.mins;
                m_inc = rbits[1];
            end
            a2d_pkg::FMT_SEC:
            begin
                m_in  = trunc.mins;
                s_in  = trunc.secs;
                s_inc = rbits[2];
            end
            a2d_pkg::FMT_TEN:
            begin
                m_in  = trunc.mins;
                s_in  = trunc.secs;
                t_in  = trunc.tenths;
                t_inc = rbits[3];
            end
        endcase

        t_sum = t_in + 4'(t_inc);
        ct    = (t_sum == 4'd10);
        s_sum = s_in + 6'(s_inc | ct);
        cs    = (s_sum == 6'd60);
        m_sum = m_in + 6'(m_inc | cs);
        cm    = (m_sum == 6'd60);

        rounded.tenths = ct ? 4'd0 : t_sum;
        rounded.secs   = cs ? 6'd0 : s_sum;
        rounded.mins   = cm ? 6'd0 : m_sum;
        rounded.deg    = trunc.deg + 8'(d_inc | cm);
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives signed fixed-point angles into angle_to_dms_fields under a range of
// grid spacings and checks every output beat against a local predictor of the
// hemisphere, degree, minute, second and tenth fields, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          FB        = 24;
    localparam logic [63:0] DEG_ONE   = 64'd1 << FB;
    localparam logic [63:0] FRAC_MASK = DEG_ONE - 64'd1;
    localparam logic [63:0] HALF_LSB  = 64'd1 << (FB - 1);
    localparam logic [63:0] MAG_CAP   = 64'd180 * DEG_ONE;
    localparam longint      DEG       = longint'(1) << FB;

    localparam logic [1:0] AXIS_LAT    = 2'd0;
    localparam logic [1:0] AXIS_LON    = 2'd1;
    localparam logic [1:0] AXIS_BAD_LO = 2'd2;
    localparam logic [1:0] AXIS_BAD_HI = 2'd3;

    localparam logic [1:0] HEMI_NORTH = 2'd0;
    localparam logic [1:0] HEMI_SOUTH = 2'd1;
    localparam logic [1:0] HEMI_EAST  = 2'd2;
    localparam logic [1:0] HEMI_WEST  = 2'd3;

    typedef struct packed {
        logic [1:0]    hemisphere;
        a2d_pkg::dms_t dms;
        logic [1:0]    fmt;
        logic          bad;
    } dms_result_t;

    logic                               clk;
    logic                               rst_n        = 1'b0;
    logic                               cfg_wr_en    = 1'b0;
    logic [a2d_pkg::GRID_W-1:0]         cfg_wr_data  = '0;
    logic                               in_valid     = 1'b0;
    logic                               in_stall;
    logic signed [a2d_pkg::ANGLE_W-1:0] angle        = '0;
    logic [1:0]                         axis_kind    = AXIS_LAT;
    logic                               out_valid;
    logic                               out_stall    = 1'b0;
    logic [1:0]                         hemisphere;
    logic [7:0]                         whole_degrees;
    logic [5:0]                         arc_minutes;
    logic [5:0]                         arc_seconds;
    logic [3:0]                         second_tenths;
    logic [1:0]                         format_used;
    logic                               bad_axis;

    logic [a2d_pkg::GRID_W-1:0] grid_now = a2d_pkg::GRID_RESET;
    dms_result_t                pending_dms[$];
    int                         err_count = 0;
    bit                         pace_on   = 1'b1;

    angle_to_dms_fields #(
        .FRACTION_BITS (FB)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .angle         (angle),
        .axis_kind     (axis_kind),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hemisphere    (hemisphere),
        .whole_degrees (whole_degrees),
        .arc_minutes   (arc_minutes),
        .arc_seconds   (arc_seconds),
        .second_tenths (second_tenths),
        .format_used   (format_used),
        .bad_axis      (bad_axis)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic logic [1:0] format_for_grid(input logic [a2d_pkg::GRID_W-1:0] g);
        logic [63:0] g64;
        g64 = {33'd0, g};
        if (g64 >= DEG_ONE)
            return a2d_pkg::FMT_DEG;
        if (g64 * 60 >= DEG_ONE && g64 * 60 <= 59 * DEG_ONE)
            return a2d_pkg::FMT_MIN;
        if (g64 * 3600 >= DEG_ONE && g64 * 3600 <= 59 * DEG_ONE)
            return a2d_pkg::FMT_SEC;
        return a2d_pkg::FMT_TEN;
    endfunction

    function automatic dms_result_t predict_dms(input logic [a2d_pkg::ANGLE_W-1:0] a,
                                                input logic [1:0] axis,
                                                input logic [1:0] fmt);
        dms_result_t r;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] frac;
        logic [63:0] deg;
        logic [63:0] mins;
        logic [63:0] secs;
        logic [63:0] tenths;
        logic [63:0] t;
        r = '0;
        if (axis != AXIS_LAT && axis != AXIS_LON)
        begin
            r.bad = 1'b1;
            return r;
        end
        neg  = a[a2d_pkg::ANGLE_W-1];
        mag  = neg ? (64'd1 << a2d_pkg::ANGLE_W) - {31'd0, a} : {31'd0, a};
        if (mag > MAG_CAP)
            mag = MAG_CAP;
        deg    = mag >> FB;
        frac   = mag & FRAC_MASK;
        mins   = 0;
        secs   = 0;
        tenths = 0;
        if (fmt == a2d_pkg::FMT_DEG)
        begin
            deg = (mag + HALF_LSB) >> FB;
        end
        else if (fmt == a2d_pkg::FMT_MIN)
        begin
            mins = (frac * 60 + HALF_LSB) >> FB;
            if (mins >= 60)
            begin
                mins = 0;
                deg++;
            end
        end
        else
        begin
            t    = frac * 60;
            mins = t >> FB;
            t    = (t & FRAC_MASK) * 60;
            if (fmt == a2d_pkg::FMT_SEC)
                secs = (t + HALF_LSB) >> FB;
            else
            begin
                secs   = t >> FB;
                t      = (t & FRAC_MASK) * 10;
                tenths = (t + HALF_LSB) >> FB;
                if (tenths >= 10)
                begin
                    tenths = 0;
                    secs++;
                end
            end
            if (secs >= 60)
            begin
                secs = 0;
                mins++;
                if (mins >= 60)
                begin
                    mins = 0;
                    deg++;
                end
            end
        end
        if (axis == AXIS_LAT)
            r.hemisphere = neg ? HEMI_SOUTH : HEMI_NORTH;
        else
            r.hemisphere = neg ? HEMI_WEST : HEMI_EAST;
        r.dms.deg    = deg[7:0];
        r.dms.mins   = mins[5:0];
        r.dms.secs   = secs[5:0];
        r.dms.tenths = tenths[3:0];
        r.fmt        = fmt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // score each output beat; handshake inputs are stable at the falling edge
    always @(negedge clk)
    begin
        dms_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dms.size() == 0)
            begin
                $display("%0t: output beat with none expected, expected none actual deg %0d",
                         $time, whole_degrees);
                err_count++;
            end
            else
            begin
                want = pending_dms.pop_front();
                check_field("hemisphere", 8'(want.hemisphere), 8'(hemisphere));
                check_field("whole_degrees", want.dms.deg, whole_degrees);
                check_field("arc_minutes", 8'(want.dms.mins), 8'(arc_minutes));
                check_field("arc_seconds", 8'(want.dms.secs), 8'(arc_seconds));
                check_field("second_tenths", 8'(want.dms.tenths), 8'(second_tenths));
                check_field("format_used", 8'(want.fmt), 8'(format_used));
                check_field("bad_axis", 8'(want.bad), 8'(bad_axis));
            end
        end
    end

    initial
    begin
        int  run;
        bit  stalling;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (!pace_on)
                out_stall <= 1'b0;
            else if (run > 0)
                run--;
            else
            begin
                stalling  = ($urandom_range(0, 2) == 0);
                run       = stalling ? $urandom_range(0, 7) : $urandom_range(0, 15);
                out_stall <= stalling;
            end
        end
    end

    task automatic send_angle(input longint v, input logic [1:0] axis);
        logic [a2d_pkg::ANGLE_W-1:0] a;
        a = v[a2d_pkg::ANGLE_W-1:0];
        if (pace_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        angle     <= a;
        axis_kind <= axis;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        pending_dms.push_back(predict_dms(a, axis, format_for_grid(grid_now)));
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_dms.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_grid(input logic [a2d_pkg::GRID_W-1:0] g);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        grid_now  = g;
    endtask

    function automatic longint random_angle();
        longint mag;
        longint v;
        case ($urandom_range(0, 9))
            0: v = {$urandom_range(0, 1), $urandom()};
            1: v = $urandom_range(0, 1) ? (longint'(1) << 32) - 1 : -(longint'(1) << 32);
            2, 3:
            begin
                mag = $urandom_range(0, 180) * DEG + (DEG * $urandom_range(0, 59)) / 60
                      + $urandom_range(0, 128) - 64;
                if (mag < 0)
                    mag = 0;
                v = $urandom_range(0, 1) ? -mag : mag;
            end
            default:
            begin
                mag = $urandom_range(0, 180) * DEG + ($urandom() & (DEG - 1));
                if (mag > 180 * DEG)
                    mag = 180 * DEG;
                v = $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
        return v;
    endfunction

    function automatic logic [1:0] random_axis();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? AXIS_BAD_HI : AXIS_BAD_LO;
        return $urandom_range(0, 1) ? AXIS_LON : AXIS_LAT;
    endfunction

    // whole degrees at the reset spacing: saturation, sign and rounding corners
    task automatic test_degree_format();
        send_angle(0, AXIS_LAT);
        send_angle(0, AXIS_LON);
        send_angle(180 * DEG, AXIS_LON);
        send_angle(-180 * DEG, AXIS_LON);
        send_angle((longint'(1) << 32) - 1, AXIS_LAT);
        send_angle(-(longint'(1) << 32), AXIS_LAT);
        send_angle(-1, AXIS_LON);
        send_angle(DEG / 2, AXIS_LAT);
        send_angle(DEG / 2 - 1, AXIS_LAT);
        send_angle(-DEG / 2, AXIS_LON);
        send_angle(90 * DEG + 123, AXIS_BAD_LO);
        send_angle(-1, AXIS_BAD_HI);
    endtask

    // carry chains into degrees for each finer format
    task automatic test_format_carries();
        logic [a2d_pkg::GRID_W-1:0] grids[3];
        grids = '{31'd279621, 31'd4661, 31'd0};
        foreach (grids[i])
        begin
            write_grid(grids[i]);
            send_angle(DEG - 1, AXIS_LAT);
            send_angle(-(180 * DEG - 1), AXIS_LON);
            send_angle(45 * DEG + DEG / 3, AXIS_LON);
        end
    endtask

    task automatic test_random_grids();
        logic [a2d_pkg::GRID_W-1:0] grids[15];
        grids = '{a2d_pkg::GRID_RESET, 31'h7FFF_FFFF, 31'd1509949440, 31'd16777215,
                  31'd279620, 31'd279621, 31'd16497595, 31'd16497596,
                  31'd4660, 31'd4661, 31'd274959, 31'd274960, 31'd0,
                  a2d_pkg::GRID_W'($urandom_range(279621, 16497595)),
                  a2d_pkg::GRID_W'($urandom_range(4661, 274959))};
        foreach (grids[i])
        begin
            write_grid(grids[i]);
            repeat (30)
                send_angle(random_angle(), random_axis());
        end
    endtask

    // back-to-back beats with no idling on either side
    task automatic test_full_rate();
        logic [a2d_pkg::GRID_W-1:0] grids[4];
        grids = '{a2d_pkg::GRID_RESET, 31'd300000, 31'd10000, 31'd1};
        pace_on = 1'b0;
        foreach (grids[i])
        begin
            write_grid(grids[i]);
            repeat (15)
                send_angle(random_angle(), random_axis());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_degree_format();
        test_format_carries();
        test_random_grids();
        test_full_rate();
        drain_results();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
